>>> rtl/epoch_seconds_to_calendar_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for epoch_seconds_to_calendar
// Same-cycle and next-cycle implication checks on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// hold cons in the same cycle as ante
`define ESC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("esc: same-cycle check failed");

// hold cons in the cycle after ante
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("esc: next-cycle check failed");

`endif

>>> rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and calendar helpers for the epoch converter.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int unsigned SUB_W = 15;

    localparam logic [10:0] EPOCH_YEAR = 11'd1970;
    localparam logic [4:0]  ZONE_MAX   = 5'd23;
    localparam logic [4:0]  ZONE_RESET = 5'd8;

    // reciprocals for t/60 (shift 37), (t/60)/60 (shift 32) and (t/3600)/24 (shift 25)
    localparam logic [31:0] RECIP_SEC  = 32'd2290649225;
    localparam logic [31:0] RECIP_MIN  = 32'd71582789;
    localparam logic [31:0] RECIP_HOUR = 32'd1398102;

    localparam logic [5:0] MOD_60 = 6'd60;
    localparam logic [5:0] MOD_24 = 6'd24;

    localparam logic [SUB_W-1:0] YEAR_LEN      = SUB_W'(365);
    localparam logic [SUB_W-1:0] LEAP_YEAR_LEN = SUB_W'(366);

    localparam logic [4:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [SUB_W-1:0] a;
        logic [SUB_W-1:0] b;
    } t_sub_req;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             ge;
    } t_sub_rsp;

    // years reachable here are 1970..2038; 2000 is a leap year by the 400 rule
    function automatic logic is_leap(input logic [10:0] year);
        return year[1:0] == 2'b00;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        if (month < 4'd1 || month > 4'd12) begin
            d = 5'd31;
        end else begin
            d = MONTH_LEN[month];
            if (month == 4'd2 && leap) begin
                d = d + 5'd1;
            end
        end
        return d;
    endfunction

endpackage

>>> rtl/esc_sub.sv
// ----------------------------------------------------------------------------
// esc_sub
// Shared subtract and compare unit: difference a - b and a >= b.
// ----------------------------------------------------------------------------
module esc_sub (
    input  esc_pkg::t_sub_req i_req,
    output esc_pkg::t_sub_rsp o_rsp
);
    import esc_pkg::*;

    logic [SUB_W:0] wide;

    assign wide       = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.diff = wide[SUB_W-1:0];
    assign o_rsp.ge   = ~wide[SUB_W];

endmodule

>>> rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 UTC to a zoned calendar date and time.
//
//   channel  | valid / ready                   | payload
//   ---------+---------------------------------+-------------------------------
//   input    | i_epoch_valid / o_epoch_ready   | i_epoch_seconds
//   result   | o_res_valid / i_res_ready       | o_year .. o_second
//   config   | i_cfg_valid / o_cfg_ready       | i_cfg_zone_offset_hours
//
// An item passes through three reciprocal divisions by 60, 60 and 24, each
// a multiply state and a remainder state, then the year and month walks on
// one shared 15-bit subtract and compare unit, then a finish state.
// Reset is synchronous, active low; the zone offset resets to 8 hours.
// The input is ready only when idle; the finish state waits while the
// previous result is still not taken.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_epoch_valid,
    output logic        o_epoch_ready,
    input  logic [30:0] i_epoch_seconds,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [10:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_zone_offset_hours
);
    import esc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_REM   = 6'b000100,
        S_YEAR  = 6'b001000,
        S_MONTH = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        P_SEC  = 3'b001,
        P_MIN  = 3'b010,
        P_HOUR = 3'b100
    } t_div_phase;

    t_state     r_state, n_state;
    t_div_phase r_phase, n_phase;
    logic [4:0]  r_zone, n_zone;
    logic [30:0] r_x, n_x;
    logic [62:0] r_prod, n_prod;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;
    logic [14:0] r_days, n_days;
    logic [10:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic        r_leap, n_leap;
    logic        r_res_valid, n_res_valid;
    logic [10:0] r_out_year, n_out_year;
    logic [3:0]  r_out_month, n_out_month;
    logic [4:0]  r_out_day, n_out_day;
    logic [4:0]  r_out_hour, n_out_hour;
    logic [5:0]  r_out_min, n_out_min;
    logic [5:0]  r_out_sec, n_out_sec;

    t_sub_req    sub_req;
    t_sub_rsp    sub_rsp;
    logic [31:0] recip;
    logic [30:0] quo;
    logic [5:0]  div_d;
    logic [5:0]  rem;
    logic [4:0]  mlen;
    logic [4:0]  off;
    logic [5:0]  hsum;
    logic        hcarry;
    logic [5:0]  dsum;

    esc_sub u_sub (
        .i_req (sub_req),
        .o_rsp (sub_rsp)
    );

    assign o_epoch_ready  = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_res_valid    = r_res_valid;
    assign o_year         = r_out_year;
    assign o_month        = r_out_month;
    assign o_day_of_month = r_out_day;
    assign o_hour         = r_out_hour;
    assign o_minute       = r_out_min;
    assign o_second       = r_out_sec;

    always_comb begin
        unique case (r_phase)
            P_SEC: begin
                recip = RECIP_SEC;
                quo   = {5'd0, r_prod[62:37]};
                div_d = MOD_60;
            end
            P_MIN: begin
                recip = RECIP_MIN;
                quo   = {11'd0, r_prod[51:32]};
                div_d = MOD_60;
            end
            P_HOUR: begin
                recip = RECIP_HOUR;
                quo   = {16'd0, r_prod[39:25]};
                div_d = MOD_24;
            end
            default: begin
                recip = RECIP_SEC;
                quo   = {5'd0, r_prod[62:37]};
                div_d = MOD_60;
            end
        endcase
        rem    = r_x[5:0] - quo[5:0] * div_d;
        mlen   = days_in(r_month, r_leap);
        off    = (r_zone > ZONE_MAX) ? ZONE_MAX : r_zone;
        hsum   = {1'b0, r_hour} + {1'b0, off};
        hcarry = (hsum >= 6'd24);
        dsum   = {1'b0, r_days[4:0]} + 6'd1 + {5'd0, hcarry};

        n_state     = r_state;
        n_phase     = r_phase;
        n_zone      = r_zone;
        n_x         = r_x;
        n_prod      = r_prod;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hour      = r_hour;
        n_days      = r_days;
        n_year      = r_year;
        n_month     = r_month;
        n_leap      = r_leap;
        n_res_valid = r_res_valid;
        n_out_year  = r_out_year;
        n_out_month = r_out_month;
        n_out_day   = r_out_day;
        n_out_hour  = r_out_hour;
        n_out_min   = r_out_min;
        n_out_sec   = r_out_sec;

        sub_req.a = r_days;
        sub_req.b = is_leap(r_year) ? LEAP_YEAR_LEN : YEAR_LEN;

        if (i_cfg_valid) begin
            n_zone = i_cfg_zone_offset_hours;
        end
        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_epoch_valid) begin
                    n_x     = i_epoch_seconds;
                    n_phase = P_SEC;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = {32'd0, r_x} * {31'd0, recip};
                n_state = S_REM;
            end
            S_REM: begin
                n_x = quo;
                unique case (r_phase)
                    P_SEC: begin
                        n_sec   = rem;
                        n_phase = P_MIN;
                        n_state = S_MUL;
                    end
                    P_MIN: begin
                        n_min   = rem;
                        n_phase = P_HOUR;
                        n_state = S_MUL;
                    end
                    P_HOUR: begin
                        n_hour  = rem[4:0];
                        n_days  = quo[14:0];
                        n_year  = EPOCH_YEAR;
                        n_state = S_YEAR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_YEAR: begin
                if (sub_rsp.ge) begin
                    n_days = sub_rsp.diff;
                    n_year = r_year + 11'd1;
                end else begin
                    n_leap  = is_leap(r_year);
                    n_month = 4'd1;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                sub_req.b = {10'd0, mlen};
                if (r_month < 4'd12 && sub_rsp.ge) begin
                    n_days  = sub_rsp.diff;
                    n_month = r_month + 4'd1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_res_valid || i_res_ready) begin
                    n_out_sec   = r_sec;
                    n_out_min   = r_min;
                    n_out_hour  = hcarry ? 5'(hsum - 6'd24) : hsum[4:0];
                    n_out_day   = dsum[4:0];
                    n_out_month = r_month;
                    n_out_year  = r_year;
                    if (dsum > {1'b0, mlen}) begin
                        n_out_day = 5'd1;
                        if (r_month >= 4'd12) begin
                            n_out_month = 4'd1;
                            n_out_year  = r_year + 11'd1;
                        end else begin
                            n_out_month = r_month + 4'd1;
                        end
                    end
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_SEC;
            r_zone      <= ZONE_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_zone      <= n_zone;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_prod      <= n_prod;
        r_sec       <= n_sec;
        r_min       <= n_min;
        r_hour      <= n_hour;
        r_days      <= n_days;
        r_year      <= n_year;
        r_month     <= n_month;
        r_leap      <= n_leap;
        r_out_year  <= n_out_year;
        r_out_month <= n_out_month;
        r_out_day   <= n_out_day;
        r_out_hour  <= n_out_hour;
        r_out_min   <= n_out_min;
        r_out_sec   <= n_out_sec;
    end

`include "epoch_seconds_to_calendar_assert.svh"

    `ESC_ASSERT_NEXT(a_accept_starts_mul, i_epoch_valid && o_epoch_ready, r_state == S_MUL)
    `ESC_ASSERT_SAME(a_month_in_range, r_state == S_FIN, r_month >= 4'd1 && r_month <= 4'd12)
    `ESC_ASSERT_SAME(a_time_fields, o_res_valid, o_hour < 5'd24 && o_minute < 6'd60)
    `ESC_ASSERT_SAME(a_second_range, o_res_valid, o_second < 6'd60)

endmodule
